// ===== design/clkr_pkg.sv =====
// Package for the clock page replacer: frame count, derived widths,
// operation codes, controller state type and controller-to-datapath command.
// No dependencies.
`default_nettype none

package clkr_pkg;

   // Frame count; the hand wraps by plain binary overflow, so this stays a power of two.
   localparam int FRAMES  = 64;
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int CNT_W   = $clog2(FRAMES + 1);

   typedef enum logic [1:0] {
      FUNC_VICTIM = 2'd0,
      FUNC_PIN    = 2'd1,
      FUNC_UNPIN  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic search;
      logic update;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/clkr_prio.sv =====
// Rotating priority encoder: finds the first set bit at or after a start position.
// Depends on clkr_pkg.
`default_nettype none

module clkr_prio
   import clkr_pkg::*;
(
   input  wire logic [FRAMES-1:0]  vec,
   input  wire logic [FRAME_W-1:0] shift,
   output logic                    any,
   output logic [FRAME_W-1:0]      idx,
   output logic [FRAMES-1:0]       below
);

   logic [2*FRAMES-1:0] dbl;
   logic [FRAMES-1:0]   rot;
   logic [FRAMES-1:0]   low;
   logic [FRAME_W-1:0]  idx_rot;

   assign dbl = {vec, vec} >> shift;
   assign rot = dbl[FRAMES-1:0];
   // isolate the lowest set bit
   assign low   = rot & (~rot + FRAMES'(1));
   assign below = low - FRAMES'(1);
   assign any   = |rot;

   always_comb begin
      idx_rot = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (low[i]) begin
            idx_rot = idx_rot | FRAME_W'(i);
         end
      end
   end

   assign idx = idx_rot + shift;

endmodule

`default_nettype wire

// ===== design/clkr_ctrl.sv =====
// Controller for the clock page replacer: sequences accept, search and commit,
// owns the result valid flag. Depends on clkr_pkg.
`default_nettype none

module clkr_ctrl
   import clkr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_func,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // commit only when the result register can take the word
            if (out_free) begin
               cmd.update = 1'b1;
               req_stall  = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_valid && !req_stall) begin
         cmd.load_req = 1'b1;
         state_in     = (req_func == FUNC_VICTIM) ? ST_SEARCH : ST_UPDATE;
      end
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_search_then_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |=> state_ff == ST_UPDATE)
      else $error("search not followed by update");

   a_update_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit over an untaken result");

   a_no_accept_in_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> !accept)
      else $error("request taken during search");

endmodule

`default_nettype wire

// ===== design/clkr_datapath.sv =====
// Datapath for the clock page replacer: present and reference bit vectors,
// hand, present count, search registers and result register.
// Depends on clkr_pkg and clkr_prio.
`default_nettype none

module clkr_datapath
   import clkr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [1:0]         req_func,
   input  wire logic [FRAME_W-1:0] req_frame,
   output logic                    rsp_found,
   output logic [FRAME_W-1:0]      rsp_victim_frame,
   output logic [CNT_W-1:0]        rsp_present_count
);

   logic [FRAMES-1:0]  present_ff, present_in;
   logic [FRAMES-1:0]  reference_ff, reference_in;
   logic [FRAME_W-1:0] hand_ff, hand_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [1:0]         func_ff, func_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               any_ff, any_in;
   logic [FRAME_W-1:0] win_ff, win_in;
   logic [FRAMES-1:0]  mask_ff, mask_in;
   logic [FRAME_W-1:0] shift_ff, shift_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0] rsp_victim_ff, rsp_victim_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [FRAME_W-1:0]  shift;
   logic [FRAMES-1:0]   cand_vec;
   logic                cand_any, pres_any;
   logic [FRAME_W-1:0]  cand_idx, pres_idx;
   logic [FRAMES-1:0]   cand_below;
   logic [2*FRAMES-1:0] mask_dbl;
   logic [FRAMES-1:0]   clear_mask;

   // search starts one past the hand
   assign shift    = hand_ff + FRAME_W'(1);
   assign cand_vec = present_ff & ~reference_ff;

   clkr_prio u_cand (
      .vec   (cand_vec),
      .shift (shift),
      .any   (cand_any),
      .idx   (cand_idx),
      .below (cand_below)
   );

   clkr_prio u_pres (
      .vec   (present_ff),
      .shift (shift),
      .any   (pres_any),
      .idx   (pres_idx),
      .below ()
   );

   // rotate the passed-over mask back to frame order
   assign mask_dbl   = {mask_ff, mask_ff} << shift_ff;
   assign clear_mask = mask_dbl[2*FRAMES-1:FRAMES];

   always_comb begin
      present_in    = present_ff;
      reference_in  = reference_ff;
      hand_in       = hand_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      frame_in      = frame_ff;
      any_in        = any_ff;
      win_in        = win_ff;
      mask_in       = mask_ff;
      shift_in      = shift_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.load_req) begin
         func_in  = req_func;
         frame_in = req_frame;
      end

      if (cmd.search) begin
         any_in   = pres_any;
         shift_in = shift;
         if (cand_any) begin
            win_in  = cand_idx;
            mask_in = cand_below;
         end else begin
            // full lap: every reference bit is cleared, first present frame goes
            win_in  = pres_idx;
            mask_in = '1;
         end
      end

      if (cmd.update) begin
         rsp_found_in  = 1'b0;
         rsp_victim_in = '0;
         case (func_ff)
            FUNC_VICTIM: begin
               if (any_ff) begin
                  reference_in         = reference_ff & ~clear_mask;
                  present_in[win_ff]   = 1'b0;
                  reference_in[win_ff] = 1'b0;
                  hand_in              = win_ff;
                  count_in             = count_ff - CNT_W'(1);
                  rsp_found_in         = 1'b1;
                  rsp_victim_in        = win_ff;
               end
            end
            FUNC_PIN: begin
               if (present_ff[frame_ff]) begin
                  count_in = count_ff - CNT_W'(1);
               end
               present_in[frame_ff]   = 1'b0;
               reference_in[frame_ff] = 1'b0;
            end
            FUNC_UNPIN: begin
               if (!present_ff[frame_ff]) begin
                  count_in = count_ff + CNT_W'(1);
               end
               present_in[frame_ff]   = 1'b1;
               reference_in[frame_ff] = 1'b1;
            end
            default: begin
            end
         endcase
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         reference_ff <= '0;
         hand_ff      <= FRAME_W'(FRAMES - 1);
         count_ff     <= '0;
      end else begin
         present_ff   <= present_in;
         reference_ff <= reference_in;
         hand_ff      <= hand_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      frame_ff      <= frame_in;
      any_ff        <= any_in;
      win_ff        <= win_in;
      mask_ff       <= mask_in;
      shift_ff      <= shift_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_found         = rsp_found_ff;
   assign rsp_victim_frame  = rsp_victim_ff;
   assign rsp_present_count = rsp_count_ff;

   a_ref_implies_present: assert property (@(posedge clock) disable iff (reset)
      (reference_ff & ~present_ff) == '0)
      else $error("reference bit set on an absent frame");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(present_ff)))
      else $error("present count out of step with present bits");

   a_hand_on_victim: assert property (@(posedge clock) disable iff (reset)
      cmd.update && func_ff == FUNC_VICTIM && any_ff
      |=> hand_ff == rsp_victim_ff && !present_ff[rsp_victim_ff])
      else $error("hand not left on the removed victim");

endmodule

`default_nettype wire

// ===== design/clock_page_replacer.sv =====
// Clock (second-chance) page replacer over FRAMES frames.
//
// Request channel (req_valid / req_stall): req_func selects pick victim,
// pin or unpin; req_frame names the frame for pin and unpin.
// Result channel (rsp_valid / rsp_stall): one word per request with
// rsp_found, rsp_victim_frame and rsp_present_count (count after the op).
// A word moves at a rising edge where valid is high and stall is low.
//
// Each request goes to the commit state, which commits the bit updates and
// writes the result register; a victim request first passes the search
// state, which holds off new requests and registers the output of the
// rotating priority encoders over the present and unreferenced vectors;
// its commit moves the hand. Pin and unpin run one request per cycle unless stalled.
// The result sits in an output register; the next request is taken while
// it waits, and a commit holds until the register is taken, with req_stall
// raised meanwhile.
// Reset (synchronous, active high) empties every frame, places the hand on
// the last frame so the first search begins at frame 0, and drops rsp_valid.
// Depends on clkr_pkg, clkr_ctrl and clkr_datapath.
`default_nettype none

module clock_page_replacer
   import clkr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic [FRAME_W-1:0] req_frame,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic [FRAME_W-1:0]      rsp_victim_frame,
   output logic [CNT_W-1:0]        rsp_present_count
);

   cmd_type cmd;

   clkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   clkr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_frame         (req_frame),
      .rsp_found         (rsp_found),
      .rsp_victim_frame  (rsp_victim_frame),
      .rsp_present_count (rsp_present_count)
   );

endmodule

`default_nettype wire
